### design/etfi_pkg.sv
// Shared types, register indexes, reset values and fixed-point helpers of the fractal iterator.
`default_nettype none

package etfi_pkg;

  localparam int FRAC_BITS_DEF = 26;
  localparam int COORD_W       = 32;
  localparam int LIMIT_W       = 16;
  localparam int PIX_W         = 10;
  localparam int MODE_W        = 2;
  localparam int CFG_IDX_W     = 3;
  localparam int PROD_W        = 2 * COORD_W;
  localparam int SUM_W         = PROD_W + 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_RE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_RE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_IM = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_IM   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_JULIA_RE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_JULIA_IM  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd7;

  // fractal modes; the unused code runs as Mandelbrot
  localparam logic [MODE_W-1:0] MODE_MANDEL = 2'd0;
  localparam logic [MODE_W-1:0] MODE_JULIA  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SHIP   = 2'd2;

  localparam logic signed [COORD_W-1:0] ORIGIN_RST = -32'sd134217728;
  localparam logic signed [COORD_W-1:0] STEP_RST   = 32'sd262144;
  localparam logic signed [COORD_W-1:0] JULIA_RST  = 32'sd0;
  localparam logic [LIMIT_W-1:0]        LIMIT_RST  = 16'd100;
  localparam logic [MODE_W-1:0]         MODE_RST   = MODE_MANDEL;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_col;
    logic [PIX_W-1:0] pixel_row;
  } in_word_t;

  typedef struct packed {
    logic [PIX_W-1:0]   out_col;
    logic [PIX_W-1:0]   out_row;
    logic [LIMIT_W-1:0] iter_count;
    logic               inside_set;
  } out_word_t;

  // clamp a wide signed sum into the signed 32-bit range
  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > 66'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -66'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = signed'(v[COORD_W-1:0]);
    end
    return r;
  endfunction

  // absolute value, saturating the most negative code
  function automatic logic signed [COORD_W-1:0] abs_sat(input logic signed [COORD_W-1:0] v);
    logic signed [COORD_W-1:0] r;
    if (v == 32'sh80000000) begin
      r = 32'sh7FFFFFFF;
    end else if (v < 0) begin
      r = -v;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // exact magnitude as an unsigned value
  function automatic logic [COORD_W-1:0] mag(input logic signed [COORD_W-1:0] v);
    logic [COORD_W-1:0] r;
    if (v < 0) begin
      r = unsigned'(-v);
    end else begin
      r = unsigned'(v);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### design/escape_time_fractal_iterator.sv
// Escape-time fractal iterator: pixel mapping and z = z^2 + c loop on one shared multiplier.
`default_nettype none

// Takes one pixel word (column, row), maps it to the complex plane as
// origin + index * step on each axis, and iterates z = z^2 + c in signed
// fixed point with FRAC_BITS fraction bits (Q6.26 by default) until
// |re| + |im| > 4 after an update or until iteration_limit updates have run.
// Mandelbrot starts z at 0 with c at the pixel; Julia starts z at the pixel
// with c from julia_re/julia_im; burning ship is Mandelbrot with |re| and
// |im| taken before each squaring. The result word echoes the pixel and
// carries the count of non-escaping updates and an inside flag.
// Timing: one 32x32 signed multiplier does all the work, so a pixel runs
// through the mapping states (S_MAP_RE, S_MAP_IM, S_MAP_DONE), then per
// iteration the three products, the update and the escape test, then S_DONE
// hands the word to the output register. The sequencer then returns to idle
// to take the next word, so it takes no new pixel before the last one's word
// has been handed to the output register.
// in_stall is low only while the sequencer is idle; a finished word waits
// in the output register, so the next pixel can start while it is stalled.
// Write configuration only while no pixel is in flight.
module escape_time_fractal_iterator
  import etfi_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_word_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_word_t                 out_data,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [COORD_W-1:0]   cfg_data
);

  localparam logic [PROD_W-1:0] ESC_BOUND = PROD_W'(4) << FRAC_BITS;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_MAP_RE   = 10'b00_0000_0010,
    S_MAP_IM   = 10'b00_0000_0100,
    S_MAP_DONE = 10'b00_0000_1000,
    S_SQ_X     = 10'b00_0001_0000,
    S_SQ_Y     = 10'b00_0010_0000,
    S_XY       = 10'b00_0100_0000,
    S_UPD      = 10'b00_1000_0000,
    S_CHK      = 10'b01_0000_0000,
    S_DONE     = 10'b10_0000_0000
  } state_t;

  // configuration registers
  logic signed [COORD_W-1:0] origin_re_r, step_re_r, origin_im_r, step_im_r;
  logic signed [COORD_W-1:0] julia_re_r, julia_im_r;
  logic [LIMIT_W-1:0]        limit_r;
  logic [MODE_W-1:0]         mode_r;

  // sequencer and datapath
  state_t                    state_r, state_nxt;
  logic [LIMIT_W-1:0]        n_r, n_nxt;
  in_word_t                  pix_r;
  logic signed [COORD_W-1:0] p_re_r;
  logic signed [COORD_W-1:0] zr_r, zi_r, cr_r, ci_r;
  logic signed [PROD_W-1:0]  prod_r, xx_r, yy_r;
  logic                      out_valid_r, out_valid_nxt;
  out_word_t                 out_data_r;

  logic                      julia, ship;
  logic signed [COORD_W-1:0] x_op, y_op, mul_a, mul_b, p_im;
  logic [COORD_W:0]          esc_sum;
  logic                      escaped, out_free;

  assign julia = (mode_r == MODE_JULIA);
  assign ship  = (mode_r == MODE_SHIP);

  // burning ship folds z into the first quadrant before squaring
  assign x_op = ship ? abs_sat(zr_r) : zr_r;
  assign y_op = ship ? abs_sat(zi_r) : zi_r;

  // operand select for the shared multiplier
  always_comb begin
    case (state_r)
      S_MAP_RE: begin
        mul_a = signed'(COORD_W'(pix_r.pixel_col));
        mul_b = step_re_r;
      end
      S_MAP_IM: begin
        mul_a = signed'(COORD_W'(pix_r.pixel_row));
        mul_b = step_im_r;
      end
      S_SQ_X: begin
        mul_a = x_op;
        mul_b = x_op;
      end
      S_SQ_Y: begin
        mul_a = y_op;
        mul_b = y_op;
      end
      default: begin
        mul_a = x_op;
        mul_b = y_op;
      end
    endcase
  end

  assign p_im     = sat32(SUM_W'(origin_im_r) + SUM_W'(prod_r));
  assign esc_sum  = (COORD_W+1)'(mag(zr_r)) + (COORD_W+1)'(mag(zi_r));
  assign escaped  = PROD_W'(esc_sum) > ESC_BOUND;
  assign out_free = !out_valid_r || !out_stall;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_re_r <= ORIGIN_RST;
      step_re_r   <= STEP_RST;
      origin_im_r <= ORIGIN_RST;
      step_im_r   <= STEP_RST;
      julia_re_r  <= JULIA_RST;
      julia_im_r  <= JULIA_RST;
      limit_r     <= LIMIT_RST;
      mode_r      <= MODE_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_ORIGIN_RE: origin_re_r <= signed'(cfg_data);
        REG_STEP_RE:   step_re_r   <= signed'(cfg_data);
        REG_ORIGIN_IM: origin_im_r <= signed'(cfg_data);
        REG_STEP_IM:   step_im_r   <= signed'(cfg_data);
        REG_JULIA_RE:  julia_re_r  <= signed'(cfg_data);
        REG_JULIA_IM:  julia_im_r  <= signed'(cfg_data);
        REG_LIMIT:     limit_r     <= cfg_data[LIMIT_W-1:0];
        REG_MODE:      mode_r      <= cfg_data[MODE_W-1:0];
        default:       ;
      endcase
    end
  end

  // sequencer: map, then loop square/square/cross/update/test
  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_MAP_RE;
        end
      end
      S_MAP_RE:   state_nxt = S_MAP_IM;
      S_MAP_IM:   state_nxt = S_MAP_DONE;
      S_MAP_DONE: begin
        n_nxt     = '0;
        // a zero limit runs no update at all
        state_nxt = (limit_r == '0) ? S_DONE : S_SQ_X;
      end
      S_SQ_X:     state_nxt = S_SQ_Y;
      S_SQ_Y:     state_nxt = S_XY;
      S_XY:       state_nxt = S_UPD;
      S_UPD:      state_nxt = S_CHK;
      S_CHK: begin
        if (escaped) begin
          state_nxt = S_DONE;
        end else begin
          n_nxt     = LIMIT_W'(n_r + 1'b1);
          state_nxt = (n_nxt == limit_r) ? S_DONE : S_SQ_X;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          pix_r <= in_data;
        end
      end
      S_MAP_IM: p_re_r <= sat32(SUM_W'(origin_re_r) + SUM_W'(prod_r));
      S_MAP_DONE: begin
        if (julia) begin
          zr_r <= p_re_r;
          zi_r <= p_im;
          cr_r <= julia_re_r;
          ci_r <= julia_im_r;
        end else begin
          zr_r <= '0;
          zi_r <= '0;
          cr_r <= p_re_r;
          ci_r <= p_im;
        end
      end
      S_SQ_Y: xx_r <= prod_r >>> FRAC_BITS;
      S_XY:   yy_r <= prod_r >>> FRAC_BITS;
      S_UPD: begin
        // 2xy is the cross product shifted one bit less
        zr_r <= sat32(SUM_W'(xx_r) - SUM_W'(yy_r) + SUM_W'(cr_r));
        zi_r <= sat32(SUM_W'(prod_r >>> (FRAC_BITS - 1)) + SUM_W'(ci_r));
      end
      S_DONE: begin
        if (out_free) begin
          out_data_r.out_col    <= pix_r.pixel_col;
          out_data_r.out_row    <= pix_r.pixel_row;
          out_data_r.iter_count <= n_r;
          out_data_r.inside_set <= (n_r == limit_r);
        end
      end
      default: ;
    endcase
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

### design/etfi_checker.sv
// Port-level checker for the fractal iterator, bound to the top level.
`default_nettype none

module etfi_checker
  import etfi_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_stall,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire out_word_t            out_data,
  input wire logic                 cfg_wr_en,
  input wire logic [CFG_IDX_W-1:0] cfg_index,
  input wire logic [COORD_W-1:0]   cfg_data
);

  logic [LIMIT_W-1:0] lim_r;

  // shadow the iteration limit from the write port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r <= LIMIT_RST;
    end else if (cfg_wr_en && cfg_index == REG_LIMIT) begin
      lim_r <= cfg_data[LIMIT_W-1:0];
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output word changed or dropped");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again while a pixel is in flight");

  a_inside_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.inside_set |-> out_data.iter_count == lim_r)
    else $error("inside pixel without a full count");

  a_escape_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.inside_set |-> out_data.iter_count < lim_r)
    else $error("escaped pixel count at or above limit");

endmodule

bind escape_time_fractal_iterator etfi_checker u_etfi_checker (.*);

`default_nettype wire

### dv/tb_top.sv
// Self-checking testbench for the escape-time fractal iterator.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import etfi_pkg::*;

  // The spare mode code has no name in the package; the block runs it as Mandelbrot.
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  localparam longint ESCAPE_BOUND = 64'sd4 <<< FRAC_BITS_DEF;
  localparam logic [COORD_W-1:0] S32_MAX_CODE = 32'h7FFF_FFFF;
  localparam logic [COORD_W-1:0] S32_MIN_CODE = 32'h8000_0000;
  localparam logic [COORD_W-1:0] JULIA_RE_DEMO = -32'sd53687091;  // about -0.8
  localparam logic [COORD_W-1:0] JULIA_IM_DEMO = 32'sd10468982;   // about 0.156
  localparam logic [LIMIT_W-1:0] LIMIT_MAX = 16'hFFFF;

  localparam int RANDOM_ITEMS  = 800;
  localparam int SETTLE_CYCLES = 16;
  localparam int IDLE_PCT      = 11;
  // Must outlast one inside pixel at the largest limit, which runs all 65535 updates.
  localparam int STALL_LIMIT   = 1_400_000;
  localparam int HOLD_CYCLES   = 4000;
  localparam int HOLD_AT       = 120;
  localparam int CALM_LO       = 400;
  localparam int CALM_HI       = 520;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_word_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_word_t            out_data;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COORD_W-1:0]   cfg_data = '0;

  // Shadow copy of the register file, used by the escape-count predictor.
  longint            origin_re_q = longint'(ORIGIN_RST);
  longint            step_re_q   = longint'(STEP_RST);
  longint            origin_im_q = longint'(ORIGIN_RST);
  longint            step_im_q   = longint'(STEP_RST);
  longint            julia_re_q  = longint'(JULIA_RST);
  longint            julia_im_q  = longint'(JULIA_RST);
  int unsigned       limit_q     = 32'(LIMIT_RST);
  logic [MODE_W-1:0] mode_q      = MODE_RST;

  in_word_t  pixel_queue[$];      // pixels waiting to be offered
  out_word_t expected_words[$];   // predicted result words, oldest first

  int error_count   = 0;
  int pixels_taken  = 0;
  int results_seen  = 0;
  int hold_left     = 0;
  bit hold_done     = 1'b0;
  int quiet_cycles  = 0;
  bit drv_gap;

  escape_time_fractal_iterator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor: signed fixed point held in 64-bit integers, clamped to 32 bits
  // wherever the block saturates.
  // ---------------------------------------------------------------------------
  function automatic longint clip_s32(input longint v);
    if (v > 64'sd2147483647) begin
      return 64'sd2147483647;
    end else if (v < -64'sd2147483648) begin
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint mag64(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic out_word_t escape_count(input in_word_t px);
    longint      p_re, p_im, zr, zi, cr, ci, x, y, xx, yy, xy2;
    int unsigned n;
    bit          ship;
    out_word_t   w;
    // Map the pixel onto the plane; each axis clamps on its own.
    p_re = clip_s32(origin_re_q + longint'(px.pixel_col) * step_re_q);
    p_im = clip_s32(origin_im_q + longint'(px.pixel_row) * step_im_q);
    ship = (mode_q == MODE_SHIP);
    // Julia starts z at the pixel; every other code starts at zero with c at the pixel.
    if (mode_q == MODE_JULIA) begin
      zr = p_re;
      zi = p_im;
      cr = julia_re_q;
      ci = julia_im_q;
    end else begin
      zr = 0;
      zi = 0;
      cr = p_re;
      ci = p_im;
    end
    n = 0;
    while (n < limit_q) begin
      x = zr;
      y = zi;
      if (ship) begin
        x = clip_s32(mag64(x));
        y = clip_s32(mag64(y));
      end
      // Truncate toward minus infinity; the cross term keeps one more bit for the 2.
      xx  = (x * x) >>> FRAC_BITS_DEF;
      yy  = (y * y) >>> FRAC_BITS_DEF;
      xy2 = (x * y) >>> (FRAC_BITS_DEF - 1);
      zr  = clip_s32(xx - yy + cr);
      zi  = clip_s32(xy2 + ci);
      if (mag64(zr) + mag64(zi) > ESCAPE_BOUND) begin
        break;
      end
      n++;
    end
    w.out_col    = px.pixel_col;
    w.out_row    = px.pixel_row;
    w.iter_count = n[LIMIT_W-1:0];
    w.inside_set = (n == limit_q);
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: offer pixels from the queue, hold a stalled word, and push
  // the prediction for every word the block takes.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_words.push_back(escape_count(in_data));
        pixels_taken++;
      end
      // Hold the word while stalled; otherwise advance or, at random, idle.
      if (!in_valid || !in_stall) begin
        drv_gap = (pixels_taken >= CALM_LO && pixels_taken < CALM_HI) ? 1'b0 :
                  ($urandom_range(0, 99) < IDLE_PCT);
        if (pixel_queue.size() != 0 && !drv_gap) begin
          in_valid <= 1'b1;
          in_data  <= pixel_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: compare every taken word with the oldest prediction and
  // drive the receiver's stall, including one long hold-off.
  // ---------------------------------------------------------------------------
  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual %p", $time, out_data);
          error_count++;
        end else begin
          want = expected_words.pop_front();
          compare_field("out_col", 32'(want.out_col), 32'(out_data.out_col));
          compare_field("out_row", 32'(want.out_row), 32'(out_data.out_row));
          compare_field("iter_count", 32'(want.iter_count), 32'(out_data.iter_count));
          compare_field("inside_set", 32'(want.inside_set), 32'(out_data.inside_set));
        end
        results_seen++;
      end
      // Hold off long enough that the block finishes a pixel, starts the next
      // and then stalls its input while the driver keeps offering. Start only
      // while enough pixels are still queued to back up behind the held word.
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && results_seen >= HOLD_AT && pixel_queue.size() > 1) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (results_seen >= CALM_LO && results_seen < CALM_HI) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Configuration and stimulus
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_ORIGIN_RE: origin_re_q = longint'(signed'(val));
      REG_STEP_RE:   step_re_q   = longint'(signed'(val));
      REG_ORIGIN_IM: origin_im_q = longint'(signed'(val));
      REG_STEP_IM:   step_im_q   = longint'(signed'(val));
      REG_JULIA_RE:  julia_re_q  = longint'(signed'(val));
      REG_JULIA_IM:  julia_im_q  = longint'(signed'(val));
      REG_LIMIT:     limit_q     = 32'(val[LIMIT_W-1:0]);
      REG_MODE:      mode_q      = val[MODE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_config(input logic [COORD_W-1:0] o_re, input logic [COORD_W-1:0] s_re,
                             input logic [COORD_W-1:0] o_im, input logic [COORD_W-1:0] s_im,
                             input logic [COORD_W-1:0] j_re, input logic [COORD_W-1:0] j_im,
                             input logic [LIMIT_W-1:0] lim, input logic [MODE_W-1:0] mode);
    write_reg(REG_ORIGIN_RE, o_re);
    write_reg(REG_STEP_RE, s_re);
    write_reg(REG_ORIGIN_IM, o_im);
    write_reg(REG_STEP_IM, s_im);
    write_reg(REG_JULIA_RE, j_re);
    write_reg(REG_JULIA_IM, j_im);
    write_reg(REG_LIMIT, {16'd0, lim});
    write_reg(REG_MODE, {30'd0, mode});
  endtask

  task automatic push_pixel(input int col, input int row);
    in_word_t px;
    px.pixel_col = col[PIX_W-1:0];
    px.pixel_row = row[PIX_W-1:0];
    pixel_queue.push_back(px);
  endtask

  // Wait on the falling edge so the driver's and monitor's updates are settled,
  // then let the block settle before any register moves.
  task automatic wait_idle();
    while (pixel_queue.size() != 0 || in_valid || expected_words.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int                 sent;
    int                 burst;
    int                 o_re, s_re, o_im, s_im, j_re, j_im;
    logic [LIMIT_W-1:0] lim;
    logic [MODE_W-1:0]  mode;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset values: Mandelbrot over [-2, 2) at 2^-8 per pixel, limit 100.
    // Corners, the origin (inside), c = -1 (inside) and alternating bit patterns.
    push_pixel(0, 0);
    push_pixel(1023, 1023);
    push_pixel(512, 512);
    push_pixel(256, 512);
    push_pixel(0, 512);
    push_pixel(1023, 0);
    push_pixel(341, 682);
    push_pixel(682, 341);
    wait_idle();

    // Julia around a connected constant.
    load_config(ORIGIN_RST, STEP_RST, ORIGIN_RST, STEP_RST, JULIA_RE_DEMO, JULIA_IM_DEMO,
                LIMIT_RST, MODE_JULIA);
    push_pixel(512, 512);
    push_pixel(600, 540);
    push_pixel(0, 0);
    wait_idle();

    // Burning ship.
    load_config(ORIGIN_RST, STEP_RST, ORIGIN_RST, STEP_RST, JULIA_RST, JULIA_RST,
                LIMIT_RST, MODE_SHIP);
    push_pixel(460, 480);
    push_pixel(300, 400);
    push_pixel(512, 512);
    wait_idle();

    // Spare mode code behaves as Mandelbrot.
    write_reg(REG_MODE, {30'd0, MODE_SPARE});
    push_pixel(256, 512);
    push_pixel(100, 100);
    wait_idle();

    // Limit of zero: no update runs, every pixel is inside with count 0.
    write_reg(REG_LIMIT, 32'd0);
    push_pixel(512, 512);
    push_pixel(5, 900);
    wait_idle();

    // Limit of one.
    write_reg(REG_LIMIT, 32'd1);
    push_pixel(512, 512);
    push_pixel(0, 0);
    wait_idle();

    // Mapping saturates in both directions.
    load_config(S32_MAX_CODE, S32_MAX_CODE, S32_MIN_CODE, S32_MIN_CODE, JULIA_RST, JULIA_RST,
                16'd10, MODE_MANDEL);
    push_pixel(1023, 1023);
    push_pixel(0, 0);
    wait_idle();

    // Julia starting from a saturated point with extreme constants.
    load_config(S32_MAX_CODE, S32_MAX_CODE, S32_MIN_CODE, S32_MIN_CODE, S32_MIN_CODE,
                S32_MAX_CODE, 16'd10, MODE_JULIA);
    push_pixel(1023, 1023);
    wait_idle();

    // Largest limit: one pixel runs the full count, one escapes on its second update.
    load_config(ORIGIN_RST, STEP_RST, ORIGIN_RST, STEP_RST, JULIA_RST, JULIA_RST,
                LIMIT_MAX, MODE_MANDEL);
    push_pixel(512, 512);
    push_pixel(0, 0);
    wait_idle();

    // Random bursts, each under a fresh register setting. Most settings frame a
    // sensible view of the plane; about one in six is raw noise.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 5) == 0) begin
        o_re = $urandom;
        s_re = $urandom;
        o_im = $urandom;
        s_im = $urandom;
        j_re = $urandom;
        j_im = $urandom;
        lim  = LIMIT_W'($urandom_range(0, 128));
      end else begin
        o_re = -int'($urandom_range(32'd33554432, 32'd167772160));
        s_re = int'($urandom_range(1, 393216) >> $urandom_range(0, 10));
        o_im = -int'($urandom_range(32'd33554432, 32'd100663296));
        s_im = int'($urandom_range(1, 393216) >> $urandom_range(0, 10));
        if ($urandom_range(0, 3) == 0) begin
          o_re = -o_re;
          s_re = -s_re;
        end
        if ($urandom_range(0, 3) == 0) begin
          o_im = -o_im;
          s_im = -s_im;
        end
        // Julia constants within +/-1.5.
        j_re = int'($urandom_range(0, 32'd201326592)) - 100663296;
        j_im = int'($urandom_range(0, 32'd201326592)) - 100663296;
        lim  = ($urandom_range(0, 7) == 0) ? LIMIT_W'($urandom_range(129, 400)) :
                                             LIMIT_W'($urandom_range(1, 128));
      end
      mode = MODE_W'($urandom_range(0, 3));
      load_config(o_re, s_re, o_im, s_im, j_re, j_im, lim, mode);
      burst = $urandom_range(20, 60);
      repeat (burst) push_pixel($urandom_range(0, 1023), $urandom_range(0, 1023));
      wait_idle();
      sent += burst;
    end

    if (error_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
